// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/ptlr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptlr_pkg
// Types and constants of the pause timeline remapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptlr_pkg;

   localparam int PAUSE_SLOTS = 64;
   localparam int TICK_BITS   = 48;
   localparam int CFG_BITS    = 16;

   localparam int IDX_BITS  = (PAUSE_SLOTS > 1) ? $clog2(PAUSE_SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(PAUSE_SLOTS + 1);
   localparam int SUM_BITS  = TICK_BITS + CNT_BITS;
   localparam int LIMIT_BITS = CFG_BITS + 20;

   localparam logic [19:0] LIMIT_PER_QUARTER = 20'd864000;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(64'd864000 * 64'd480);
   localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

   localparam int REQ_FIELD_BITS = 2 * TICK_BITS + 2;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((TICK_BITS + 7) / 8) * 8;
   localparam int FUNC_BITS      = 2;
   localparam int STATUS_BITS    = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_CLEAR    = 2'd0,
      FUNC_ADD      = 2'd1,
      FUNC_FINALIZE = 2'd2,
      FUNC_MAP      = 2'd3
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_LIMIT     = 2'd2,
      STATUS_NOT_READY = 2'd3
   } status_type;

   typedef struct packed {
      func_type               func;
      logic [TICK_BITS-1:0]   tick;
      logic [TICK_BITS-1:0]   len;
      logic                   sus;
      logic                   onset;
   } op_type;

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_SRCH_RD  = 15'b000000000000010,
      S_SRCH_CMP = 15'b000000000000100,
      S_POS_RD   = 15'b000000000001000,
      S_ADD_CHK  = 15'b000000000010000,
      S_NEW      = 15'b000000000100000,
      S_SHIFT_RD = 15'b000000001000000,
      S_SHIFT_WR = 15'b000000010000000,
      S_INSERT   = 15'b000000100000000,
      S_FIN_RD   = 15'b000001000000000,
      S_FIN_ADD  = 15'b000010000000000,
      S_FIN_WR   = 15'b000100000000000,
      S_MAP_PRE  = 15'b001000000000000,
      S_MAP_ADD  = 15'b010000000000000,
      S_DONE     = 15'b100000000000000
   } state_type;

endpackage

// ===== sv/pause_timeline_remapper_unit.sv =====
// ----------------------------------------------------------------------------
// pause_timeline_remapper_unit
// Sorted pause table with merge, prefix-sum finalize and tick remapping.
// ----------------------------------------------------------------------------
// One transaction in, one result out, one transaction at a time. Every entry
// access goes through the single registered read port of the entry memory and
// one shared compare/add path, so a map is a binary search over the n stored
// pauses, a read of the prefix sum below the found slot and an add; map before
// finalize or after an exceeded limit, clear and zero-length add go straight
// to the result. A new pause runs the same search, checks the found slot,
// moves every entry from it up and inserts; a merge searches and checks;
// finalize reads, adds and writes back each entry. The entry memory needs
// no clearing pass: entries at or above the fill count are never used.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pause_timeline_remapper_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [ptlr_pkg::CFG_BITS-1:0]       csr_wdata,   // quarter resolution, ticks
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tick[47:0], pause_length[95:48], sustain[96], onset[97], zero fill
   input  logic [ptlr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [ptlr_pkg::FUNC_BITS-1:0]      req_tuser,   // func
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ptlr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // mapped_tick
   output logic [ptlr_pkg::STATUS_BITS-1:0]    rsp_tuser    // status
);

   import ptlr_pkg::*;

   // entry memory
   logic [TICK_BITS-1:0] tick_mem [PAUSE_SLOTS];
   logic [TICK_BITS-1:0] len_mem  [PAUSE_SLOTS];
   logic                 sus_mem  [PAUSE_SLOTS];
   logic [TICK_BITS-1:0] pre_mem  [PAUSE_SLOTS];

   logic [TICK_BITS-1:0] rd_tick_ff, rd_len_ff, rd_pre_ff;
   logic                 rd_sus_ff;
   logic [IDX_BITS-1:0]  rd_addr, wr_addr;
   logic                 wr_ent_en, wr_pre_en;
   logic [TICK_BITS-1:0] wr_tick, wr_len, wr_pre;
   logic                 wr_sus;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in, req_op;
   logic [CNT_BITS-1:0]  lo_ff, lo_in, hi_ff, hi_in, k_ff, k_in;
   logic [CNT_BITS-1:0]  count_ff, count_in, mid;
   logic                 ready_ff, ready_in, exceeded_ff, exceeded_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [TICK_BITS-1:0] res_mapped_ff, res_mapped_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TICK_BITS-1:0] rsp_mapped_ff, rsp_mapped_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [LIMIT_BITS-1:0] limit_ff;

   logic                 req_fire, out_free, tick_lt, tick_eq, go_right;
   logic [TICK_BITS:0]   map_sum;
   logic [TICK_BITS-1:0] max_len, sum_sat;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_op.func  = func_type'(req_tuser);
   assign req_op.tick  = req_tdata[TICK_BITS-1:0];
   assign req_op.len   = req_tdata[2*TICK_BITS-1:TICK_BITS];
   assign req_op.sus   = req_tdata[2*TICK_BITS];
   assign req_op.onset = req_tdata[2*TICK_BITS+1];

   // shared compare and add path
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign tick_lt  = rd_tick_ff < op_ff.tick;
   assign tick_eq  = rd_tick_ff == op_ff.tick;
   assign go_right = tick_lt ||
                     (tick_eq && (op_ff.func == FUNC_MAP) && (op_ff.onset || rd_sus_ff));
   assign map_sum  = {1'b0, op_ff.tick} + {1'b0, rd_pre_ff};
   assign max_len  = (op_ff.len > rd_len_ff) ? op_ff.len : rd_len_ff;
   assign sum_sat  = (sum_ff[SUM_BITS-1:TICK_BITS] != '0) ? TICK_MAX
                                                         : sum_ff[TICK_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      ready_in      = ready_ff;
      exceeded_in   = exceeded_ff;
      sum_in        = sum_ff;
      res_mapped_in = res_mapped_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;
      wr_addr       = lo_ff[IDX_BITS-1:0];
      wr_ent_en     = 1'b0;
      wr_pre_en     = 1'b0;
      wr_tick       = rd_tick_ff;
      wr_len        = rd_len_ff;
      wr_sus        = rd_sus_ff;
      wr_pre        = sum_sat;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_op;
               lo_in         = '0;
               hi_in         = count_ff;
               res_mapped_in = '0;
               res_status_in = STATUS_OK;
               state_in      = S_DONE;
               unique case (req_op.func)
                  FUNC_CLEAR: begin
                     count_in    = '0;
                     ready_in    = 1'b0;
                     exceeded_in = 1'b0;
                  end
                  FUNC_ADD: begin
                     if (req_op.len != '0) begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  FUNC_FINALIZE: begin
                     exceeded_in = 1'b0;
                     k_in        = '0;
                     sum_in      = '0;
                     state_in    = S_FIN_RD;
                  end
                  FUNC_MAP: begin
                     priority if (!ready_ff) begin
                        res_status_in = STATUS_NOT_READY;
                     end else if (exceeded_ff) begin
                        res_status_in = STATUS_LIMIT;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SRCH_RD: begin
            rd_addr = mid[IDX_BITS-1:0];
            if (lo_ff < hi_ff) begin
               state_in = S_SRCH_CMP;
            end else if (op_ff.func == FUNC_ADD) begin
               state_in = S_POS_RD;
            end else if (lo_ff == '0) begin
               res_mapped_in = op_ff.tick;
               state_in      = S_DONE;
            end else begin
               state_in = S_MAP_PRE;
            end
         end
         S_SRCH_CMP: begin
            if (go_right) begin
               lo_in = mid + CNT_BITS'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_SRCH_RD;
         end
         S_POS_RD: begin
            rd_addr = lo_ff[IDX_BITS-1:0];
            state_in = (lo_ff < count_ff) ? S_ADD_CHK : S_NEW;
         end
         S_ADD_CHK: begin
            if (tick_eq) begin
               wr_ent_en = 1'b1;
               wr_len    = max_len;
               wr_sus    = rd_sus_ff | op_ff.sus;
               ready_in  = 1'b0;
               state_in  = S_DONE;
            end else begin
               state_in = S_NEW;
            end
         end
         S_NEW: begin
            if (count_ff >= CNT_BITS'(PAUSE_SLOTS)) begin
               res_status_in = STATUS_FULL;
               state_in      = S_DONE;
            end else begin
               k_in     = count_ff;
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            rd_addr = IDX_BITS'(k_ff - CNT_BITS'(1));
            state_in = (k_ff > lo_ff) ? S_SHIFT_WR : S_INSERT;
         end
         S_SHIFT_WR: begin
            wr_ent_en = 1'b1;
            wr_addr   = k_ff[IDX_BITS-1:0];
            k_in      = k_ff - CNT_BITS'(1);
            state_in  = S_SHIFT_RD;
         end
         S_INSERT: begin
            wr_ent_en = 1'b1;
            wr_tick   = op_ff.tick;
            wr_len    = op_ff.len;
            wr_sus    = op_ff.sus;
            count_in  = count_ff + CNT_BITS'(1);
            ready_in  = 1'b0;
            state_in  = S_DONE;
         end
         S_FIN_RD: begin
            rd_addr = k_ff[IDX_BITS-1:0];
            if (k_ff < count_ff) begin
               state_in = S_FIN_ADD;
            end else begin
               ready_in      = 1'b1;
               res_status_in = exceeded_ff ? STATUS_LIMIT : STATUS_OK;
               state_in      = S_DONE;
            end
         end
         S_FIN_ADD: begin
            sum_in   = sum_ff + SUM_BITS'(rd_len_ff);
            state_in = S_FIN_WR;
         end
         S_FIN_WR: begin
            wr_pre_en = 1'b1;
            wr_addr   = k_ff[IDX_BITS-1:0];
            if (sum_ff > SUM_BITS'(limit_ff)) begin
               exceeded_in = 1'b1;
            end
            k_in     = k_ff + CNT_BITS'(1);
            state_in = S_FIN_RD;
         end
         S_MAP_PRE: begin
            rd_addr  = IDX_BITS'(lo_ff - CNT_BITS'(1));
            state_in = S_MAP_ADD;
         end
         S_MAP_ADD: begin
            res_mapped_in = map_sum[TICK_BITS] ? TICK_MAX : map_sum[TICK_BITS-1:0];
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_status_in = rsp_status_ff;
      priority if (state_ff == S_DONE && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_mapped_in = res_mapped_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ent_en) begin
         tick_mem[wr_addr] <= wr_tick;
         len_mem[wr_addr]  <= wr_len;
         sus_mem[wr_addr]  <= wr_sus;
      end
      if (wr_pre_en) begin
         pre_mem[wr_addr] <= wr_pre;
      end
      rd_tick_ff <= tick_mem[rd_addr];
      rd_len_ff  <= len_mem[rd_addr];
      rd_sus_ff  <= sus_mem[rd_addr];
      rd_pre_ff  <= pre_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         exceeded_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ready_ff     <= ready_in;
         exceeded_ff  <= exceeded_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            limit_ff <= LIMIT_BITS'(LIMIT_PER_QUARTER) * LIMIT_BITS'(csr_wdata);
         end
      end
      op_ff         <= op_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      k_ff          <= k_in;
      sum_ff        <= sum_in;
      res_mapped_ff <= res_mapped_in;
      res_status_ff <= res_status_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_mapped_ff);
   assign rsp_tuser  = rsp_status_ff;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_BITS'(PAUSE_SLOTS), "fill count over table size")
   `ASSERT_CLK(a_insert_count, clock, reset, (state_ff == S_INSERT) |=> (count_ff == $past(count_ff) + CNT_BITS'(1)), "insert did not bump fill count")
   `ASSERT_NEVER(a_shift_full, clock, reset, (state_ff == S_SHIFT_WR) && (count_ff >= CNT_BITS'(PAUSE_SLOTS)), "entry move into a full table")
   `ASSERT_CLK(a_fail_zero, clock, reset, (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_mapped_ff == '0), "failed transaction with nonzero mapped tick")

endmodule

// ===== tb/ptlr_checker.sv =====
// ----------------------------------------------------------------------------
// ptlr_checker
// Transaction checker for the pause timeline remapper.
// ----------------------------------------------------------------------------
// Watches the request, response and register ports. A model of the pause
// table predicts the result of every accepted request. Each accepted response
// is compared with the oldest prediction, field by field.
`timescale 1ns / 1ps

module ptlr_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [ptlr_pkg::CFG_BITS-1:0]       csr_wdata,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [ptlr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [ptlr_pkg::FUNC_BITS-1:0]      req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [ptlr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic [ptlr_pkg::STATUS_BITS-1:0]    rsp_tuser,
   output int                                  mismatches,
   output int                                  checked,
   output int                                  pending
);

   import ptlr_pkg::*;

   localparam logic [CFG_BITS-1:0] QUARTER_RESET = 16'd480;

   typedef struct {
      logic [TICK_BITS-1:0] mapped;
      status_type           status;
   } remap_result_type;

   remap_result_type     due_results[$];

   logic [TICK_BITS-1:0] pause_tick   [PAUSE_SLOTS];
   logic [TICK_BITS-1:0] pause_len    [PAUSE_SLOTS];
   logic                 pause_sus    [PAUSE_SLOTS];
   logic [TICK_BITS-1:0] pause_offset [PAUSE_SLOTS];
   int                   pause_cnt;
   bit                   offsets_valid;
   bit                   over_limit;
   logic [CFG_BITS-1:0]  quarter_ticks;

   function automatic status_type table_insert(logic [TICK_BITS-1:0] tick,
                                               logic [TICK_BITS-1:0] len, logic sus);
      int pos;
      pos = 0;
      if (len == '0)
         return STATUS_OK;
      while (pos < pause_cnt && pause_tick[pos] < tick)
         pos++;
      if (pos < pause_cnt && pause_tick[pos] == tick) begin
         if (len > pause_len[pos])
            pause_len[pos] = len;
         pause_sus[pos] = pause_sus[pos] | sus;
         offsets_valid = 1'b0;
         return STATUS_OK;
      end
      if (pause_cnt >= PAUSE_SLOTS)
         return STATUS_FULL;
      for (int k = pause_cnt; k > pos; k--) begin
         pause_tick[k] = pause_tick[k-1];
         pause_len[k]  = pause_len[k-1];
         pause_sus[k]  = pause_sus[k-1];
      end
      pause_tick[pos] = tick;
      pause_len[pos]  = len;
      pause_sus[pos]  = sus;
      pause_cnt++;
      offsets_valid = 1'b0;
      return STATUS_OK;
   endfunction

   function automatic status_type table_finalize();
      logic [63:0] limit;
      logic [63:0] sum;
      logic [64:0] wide;
      limit = 64'd864000 * 64'(quarter_ticks);
      sum = '0;
      over_limit = 1'b0;
      for (int i = 0; i < pause_cnt; i++) begin
         wide = {1'b0, sum} + 65'(pause_len[i]);
         sum = wide[64] ? '1 : wide[63:0];
         pause_offset[i] = (sum > 64'(TICK_MAX)) ? TICK_MAX : sum[TICK_BITS-1:0];
         if (sum > limit)
            over_limit = 1'b1;
      end
      offsets_valid = 1'b1;
      return over_limit ? STATUS_LIMIT : STATUS_OK;
   endfunction

   function automatic logic [TICK_BITS-1:0] table_lookup(logic [TICK_BITS-1:0] tick,
                                                         logic onset);
      int lo;
      int hi;
      int mid;
      logic [TICK_BITS:0] wide;
      lo = 0;
      hi = pause_cnt;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (pause_tick[mid] < tick ||
             (pause_tick[mid] == tick && (onset || pause_sus[mid])))
            lo = mid + 1;
         else
            hi = mid;
      end
      if (lo == 0)
         return tick;
      wide = {1'b0, tick} + {1'b0, pause_offset[lo-1]};
      return wide[TICK_BITS] ? TICK_MAX : wide[TICK_BITS-1:0];
   endfunction

   function automatic remap_result_type remap_predict(func_type func,
                                                      logic [TICK_BITS-1:0] tick,
                                                      logic [TICK_BITS-1:0] len,
                                                      logic sus, logic onset);
      remap_result_type r;
      r.mapped = '0;
      r.status = STATUS_OK;
      case (func)
         FUNC_CLEAR: begin
            pause_cnt = 0;
            offsets_valid = 1'b0;
            over_limit = 1'b0;
         end
         FUNC_ADD: r.status = table_insert(tick, len, sus);
         FUNC_FINALIZE: r.status = table_finalize();
         default: begin
            if (!offsets_valid)
               r.status = STATUS_NOT_READY;
            else if (over_limit)
               r.status = STATUS_LIMIT;
            else
               r.mapped = table_lookup(tick, onset);
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      remap_result_type want;
      if (reset) begin
         pause_cnt = 0;
         offsets_valid = 1'b0;
         over_limit = 1'b0;
         quarter_ticks = QUARTER_RESET;
         mismatches = 0;
         checked = 0;
         due_results.delete();
      end else begin
         if (csr_wen)
            quarter_ticks = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual mapped_tick %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = due_results.pop_front();
               checked++;
               if (rsp_tdata !== RSP_DATA_BITS'(want.mapped)) begin
                  mismatches++;
                  $display("%0t: mapped_tick mismatch, expected %h, actual %h",
                           $time, want.mapped, rsp_tdata);
               end
               if (rsp_tuser !== want.status) begin
                  mismatches++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            due_results.push_back(remap_predict(func_type'(req_tuser),
                                                req_tdata[TICK_BITS-1:0],
                                                req_tdata[2*TICK_BITS-1:TICK_BITS],
                                                req_tdata[2*TICK_BITS],
                                                req_tdata[2*TICK_BITS+1]));
      end
   end

   // in-flight count, updated after the edge so the stimulus sees a stable value
   always @(posedge clock) begin
      if (reset) begin
         pending <= 0;
      end else begin
         pending <= pending + ((req_tvalid && req_tready) ? 1 : 0)
                            - ((rsp_tvalid && rsp_tready) ? 1 : 0);
      end
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench top for the pause timeline remapper unit.
// ----------------------------------------------------------------------------
// Drives a directed pass over the corner cases, then phases of random pause
// sequences (clear, adds with merges, finalize, maps) at several tick
// resolutions, with random back-pressure on both sides. The checker module
// predicts and compares; this module gives the verdict.
`timescale 1ns / 1ps

module tb;

   import ptlr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 125;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wen = 1'b0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic [FUNC_BITS-1:0]      req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [STATUS_BITS-1:0]    rsp_tuser;

   int                        mismatches;
   int                        checked;
   int                        pending;

   bit                        tx_steady = 1'b0;
   bit                        rx_steady = 1'b0;
   bit                        hold_req = 1'b0;
   int                        idle_cycles = 0;
   int                        sent_total = 0;
   int                        sent_by_func[4] = '{0, 0, 0, 0};
   int                        cfg_writes = 0;
   logic [TICK_BITS-1:0]      tick_base = '0;
   int                        tick_spread = 40;
   logic [TICK_BITS-1:0]      added[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pause_timeline_remapper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ptlr_checker ptlr_check (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mismatches (mismatches),
      .checked    (checked),
      .pending    (pending)
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TICK_BITS-1:0] rand48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[TICK_BITS-1:0];
   endfunction

   function automatic logic rbit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [TICK_BITS-1:0] pick_len();
      int r;
      logic [63:0] w;
      r = $urandom_range(0, 99);
      w = {$urandom(), $urandom()};
      if (r < 5)
         return '0;
      else if (r < 55)
         return TICK_BITS'($urandom_range(1, 1000));
      else if (r < 80)
         return TICK_BITS'(w[23:0]);
      else if (r < 90)
         return TICK_BITS'(w[39:0]);
      else if (r < 97)
         return w[TICK_BITS-1:0];
      return TICK_MAX;
   endfunction

   function automatic void pick_base();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20)
         tick_base = '0;
      else if (r < 35)
         tick_base = TICK_MAX - TICK_BITS'(tick_spread);
      else
         tick_base = rand48();
   endfunction

   function automatic logic [TICK_BITS-1:0] pick_add_tick(bit fresh);
      int r;
      r = $urandom_range(0, 99);
      if (!fresh && added.size() > 0 && r < 30)
         return added[$urandom_range(0, added.size() - 1)];
      else if (r < 92)
         return tick_base + TICK_BITS'($urandom_range(0, tick_spread));
      return rand48();
   endfunction

   function automatic logic [TICK_BITS-1:0] pick_map_tick();
      int r;
      logic [TICK_BITS-1:0] t;
      r = $urandom_range(0, 99);
      if (added.size() > 0 && r < 65) begin
         t = added[$urandom_range(0, added.size() - 1)];
         if (r < 45)
            return t;
         return rbit() ? t + 1'b1 : t - 1'b1;
      end else if (r < 85) begin
         return tick_base + TICK_BITS'($urandom_range(0, tick_spread));
      end
      return rand48();
   endfunction

   task automatic send_op(func_type func, logic [TICK_BITS-1:0] tick,
                          logic [TICK_BITS-1:0] len, logic sus, logic onset);
      int gap;
      gap = tx_steady ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= REQ_DATA_BITS'({onset, sus, len, tick});
      do @(posedge clock); while (!req_tready);
      sent_total++;
      sent_by_func[func]++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   task automatic write_quarter(logic [CFG_BITS-1:0] value);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_writes++;
   endtask

   task automatic pause_sequence();
      int adds;
      int maps;
      bit fill;
      logic [TICK_BITS-1:0] t;
      fill = ($urandom_range(0, 99) < 15);
      adds = fill ? $urandom_range(60, 72) : $urandom_range(1, 12);
      tick_spread = fill ? 100000 : 40;
      pick_base();
      send_op(FUNC_CLEAR, rand48(), rand48(), rbit(), rbit());
      added.delete();
      for (int i = 0; i < adds; i++) begin
         t = pick_add_tick(fill);
         send_op(FUNC_ADD, t, pick_len(), rbit(), rbit());
         added.push_back(t);
         if ($urandom_range(0, 99) < 8)
            send_op(FUNC_MAP, pick_map_tick(), rand48(), rbit(), rbit());
      end
      send_op(FUNC_FINALIZE, rand48(), rand48(), rbit(), rbit());
      maps = $urandom_range(4, 14);
      repeat (maps) send_op(FUNC_MAP, pick_map_tick(), rand48(), rbit(), rbit());
      if ($urandom_range(0, 99) < 30) begin
         send_op(FUNC_ADD, pick_add_tick(1'b0), pick_len(), rbit(), rbit());
         send_op(FUNC_MAP, pick_map_tick(), rand48(), rbit(), rbit());
         send_op(FUNC_FINALIZE, rand48(), rand48(), rbit(), rbit());
         repeat ($urandom_range(2, 6))
            send_op(FUNC_MAP, pick_map_tick(), rand48(), rbit(), rbit());
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 5))
         send_op(func_type'($urandom_range(0, 3)), pick_map_tick(), pick_len(),
                 rbit(), rbit());
   endtask

   // receiver: random ready with runs, one long hold on request
   initial begin
      int run;
      bit held;
      run = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else if (rx_steady) begin
            rsp_tready <= 1'b1;
         end else if (run > 0) begin
            run--;
         end else if ($urandom_range(0, 99) < 65) begin
            rsp_tready <= 1'b1;
            run = $urandom_range(0, 8);
         end else begin
            rsp_tready <= 1'b0;
            run = gap_len();
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int target;
      logic [CFG_BITS-1:0] quarter;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners, default resolution
      send_op(FUNC_MAP, 48'd5, '0, 1'b0, 1'b1);                 // map never finalized
      send_op(FUNC_FINALIZE, '0, '0, 1'b0, 1'b0);               // empty table
      send_op(FUNC_MAP, '0, '0, 1'b0, 1'b0);
      send_op(FUNC_MAP, TICK_MAX, TICK_MAX, 1'b1, 1'b1);
      send_op(FUNC_ADD, 48'd100, '0, 1'b1, 1'b0);               // zero length
      send_op(FUNC_ADD, 48'd100, 48'd50, 1'b0, 1'b0);
      send_op(FUNC_MAP, 48'd150, '0, 1'b0, 1'b0);               // stale prefixes
      send_op(FUNC_ADD, 48'd100, 48'd30, 1'b1, 1'b0);           // merge, shorter
      send_op(FUNC_ADD, 48'd100, 48'd80, 1'b0, 1'b1);           // merge, longer
      send_op(FUNC_ADD, '0, 48'd1, 1'b0, 1'b0);
      send_op(FUNC_ADD, TICK_MAX, 48'd7, 1'b1, 1'b1);
      send_op(FUNC_ADD, 48'd50, 48'd2, 1'b0, 1'b0);
      send_op(FUNC_FINALIZE, TICK_MAX, TICK_MAX, 1'b1, 1'b1);
      send_op(FUNC_MAP, 48'd100, '0, 1'b0, 1'b0);
      send_op(FUNC_MAP, 48'd100, '0, 1'b0, 1'b1);
      send_op(FUNC_MAP, 48'd50, '0, 1'b0, 1'b0);
      send_op(FUNC_MAP, 48'd50, '0, 1'b0, 1'b1);
      send_op(FUNC_MAP, '0, '0, 1'b0, 1'b0);
      send_op(FUNC_MAP, TICK_MAX, '0, 1'b0, 1'b1);              // saturates
      send_op(FUNC_MAP, 48'd99, '0, 1'b0, 1'b0);
      send_op(FUNC_ADD, 48'd200, TICK_MAX, 1'b0, 1'b0);
      send_op(FUNC_FINALIZE, '0, '0, 1'b0, 1'b0);               // over limit
      send_op(FUNC_MAP, 48'd300, '0, 1'b0, 1'b1);
      send_op(FUNC_CLEAR, TICK_MAX, TICK_MAX, 1'b1, 1'b1);
      send_op(FUNC_MAP, 48'd300, '0, 1'b0, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: quarter = 16'd1;
            1: quarter = 16'hFFFF;
            2: quarter = '0;
            3: quarter = 16'd480;
            default: quarter = (p % 2) ? CFG_BITS'($urandom_range(1, 16))
                                       : CFG_BITS'($urandom_range(1, 65535));
         endcase
         write_quarter(quarter);
         tx_steady = (p == 3);
         rx_steady = (p == 3);
         if (p == 5) begin
            // hold the response side while requests keep coming
            hold_req = 1'b1;
            tx_steady = 1'b1;
            pause_sequence();
            tx_steady = 1'b0;
         end
         target = sent_total + PHASE_ITEMS;
         while (sent_total < target) begin
            if ($urandom_range(0, 99) < 80)
               pause_sequence();
            else
               noise_burst();
         end
      end

      drain();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      repeat (50) @(posedge clock);

      $display("Sent %0d requests: %0d clears, %0d adds, %0d finalizes, %0d maps",
               sent_total, sent_by_func[FUNC_CLEAR], sent_by_func[FUNC_ADD],
               sent_by_func[FUNC_FINALIZE], sent_by_func[FUNC_MAP]);
      $display("Checked %0d results across %0d tick resolution settings",
               checked, cfg_writes + 1);
      if (mismatches == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/ptlr_pkg.sv
sv/pause_timeline_remapper_unit.sv
tb/ptlr_checker.sv
tb/tb.sv
